@@ src/sts_pkg.sv @@
// Shared types and constants for the searchable tag stack.
package sts_pkg;

    localparam int TAG_W     = 5;
    localparam int LEVEL_W   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_LIST  = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIST_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIST_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIST_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIST_D = 3'd3;

    // List tag reset values
    localparam logic [TAG_W-1:0] LIST_A_RST = 5'd0;
    localparam logic [TAG_W-1:0] LIST_B_RST = 5'd1;
    localparam logic [TAG_W-1:0] LIST_C_RST = 5'd2;
    localparam logic [TAG_W-1:0] LIST_D_RST = 5'd3;

    typedef enum logic [2:0] {
        KIND_CLEAR  = 3'd0,
        KIND_PUSH   = 3'd1,
        KIND_POP    = 3'd2,
        KIND_SHIFT  = 3'd3,
        KIND_TOP    = 3'd4,
        KIND_MATCH  = 3'd5,
        KIND_NEWEST = 3'd6,
        KIND_LIST   = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_SCAN
    } t_state;

    typedef logic [NUM_LIST-1:0][TAG_W-1:0] t_list_tags;

    typedef struct packed {
        t_kind               kind;
        logic [TAG_W-1:0]    tag;
        logic [LEVEL_W-1:0]  level;
    } t_query;

    // Search token handed from cell to cell, carrying the first hit
    typedef struct packed {
        logic                run;
        logic                hit;
        logic [TAG_W-1:0]    tag;
        logic [LEVEL_W-1:0]  level;
    } t_probe;

    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_ctl;

endpackage

@@ src/searchable_tag_stack.sv @@
// Top level of the searchable tag stack: control, configuration and the row of entry cells.
//
//  channel   direction  handshake                   payload
//  in        input      i_in_valid / o_in_ready     i_kind, i_item_tag, i_item_level
//  out       output     o_out_valid / i_out_ready   o_found, o_out_tag, o_out_level,
//                                                   o_entry_count, o_is_empty, o_is_full
//  cfg       input      i_cfg_we                    i_cfg_addr, i_cfg_wdata
//
// Clear, push, pop and top send no probe: the result is registered at the accept edge.
// Shift, match, newest and list check send a probe down the row of STACK_DEPTH cells,
// one cell per cycle, and the result is registered once the probe leaves the last cell.
// Reset empties the stack and loads the list tags with 0, 1, 2 and 3; no clearing pass.
// A new item is taken once the block is idle and the output register is free or being read.
module searchable_tag_stack #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [2:0]                      i_kind,
    input  logic [sts_pkg::TAG_W-1:0]       i_item_tag,
    input  logic [sts_pkg::LEVEL_W-1:0]     i_item_level,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_found,
    output logic [sts_pkg::TAG_W-1:0]       o_out_tag,
    output logic [sts_pkg::LEVEL_W-1:0]     o_out_level,
    output logic [sts_pkg::LEVEL_W-1:0]     o_entry_count,
    output logic                            o_is_empty,
    output logic                            o_is_full,
    input  logic                            i_cfg_we,
    input  logic [sts_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [sts_pkg::TAG_W-1:0]       i_cfg_wdata
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

    sts_pkg::t_state             r_state;
    sts_pkg::t_state             n_state;
    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            n_count;
    sts_pkg::t_query             r_query;
    sts_pkg::t_list_tags         r_list;
    logic                        r_out_valid;
    logic                        r_found;
    logic [sts_pkg::TAG_W-1:0]   r_out_tag;
    logic [sts_pkg::LEVEL_W-1:0] r_out_level;
    logic                        n_found;
    logic [sts_pkg::TAG_W-1:0]   n_out_tag;
    logic [sts_pkg::LEVEL_W-1:0] n_out_level;
    logic                        w_load;
    logic                        w_accept;
    logic                        w_scan_kind;
    logic                        w_done;
    logic                        w_launch;
    sts_pkg::t_kind              w_kind;
    sts_pkg::t_shift_ctl         w_ctl;
    logic [CNT_W+5:0]            w_count_ext;

    logic [sts_pkg::TAG_W-1:0]   w_tag   [STACK_DEPTH];
    logic [sts_pkg::LEVEL_W-1:0] w_level [STACK_DEPTH];
    sts_pkg::t_probe             w_probe [STACK_DEPTH+1];

    assign w_kind      = sts_pkg::t_kind'(i_kind);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_scan_kind = w_kind inside {sts_pkg::KIND_SHIFT, sts_pkg::KIND_MATCH,
                                        sts_pkg::KIND_NEWEST, sts_pkg::KIND_LIST};
    assign w_done      = w_probe[STACK_DEPTH].run;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sts_pkg::ST_IDLE:   if (w_accept && w_scan_kind) n_state = sts_pkg::ST_LAUNCH;
            sts_pkg::ST_LAUNCH: n_state = sts_pkg::ST_SCAN;
            sts_pkg::ST_SCAN:   if (w_done) n_state = sts_pkg::ST_IDLE;
            default:            n_state = sts_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_launch   = 1'b0;
        unique case (r_state)
            sts_pkg::ST_IDLE:   o_in_ready = !r_out_valid || i_out_ready;
            sts_pkg::ST_LAUNCH: w_launch   = 1'b1;
            sts_pkg::ST_SCAN:   ;
            default:            ;
        endcase
    end

    // Result and stack updates
    always_comb begin
        n_count     = r_count;
        n_found     = 1'b0;
        n_out_tag   = '0;
        n_out_level = '0;
        w_ctl       = '0;
        w_load      = 1'b0;
        if (w_accept && !w_scan_kind) begin
            w_load = 1'b1;
            case (w_kind)
                sts_pkg::KIND_CLEAR: n_count = '0;
                sts_pkg::KIND_PUSH: begin
                    if (r_count != FULL_CNT) begin
                        w_ctl.push  = 1'b1;
                        n_count     = r_count + CNT_W'(1);
                        n_found     = 1'b1;
                        n_out_tag   = i_item_tag;
                        n_out_level = i_item_level;
                    end
                end
                sts_pkg::KIND_POP: begin
                    if (r_count != '0) begin
                        w_ctl.pop   = 1'b1;
                        n_count     = r_count - CNT_W'(1);
                        n_found     = 1'b1;
                        n_out_tag   = w_tag[0];
                        n_out_level = w_level[0];
                    end
                end
                sts_pkg::KIND_TOP: begin
                    if (r_count != '0) begin
                        n_found     = 1'b1;
                        n_out_tag   = w_tag[0];
                        n_out_level = w_level[0];
                    end
                end
                default: ;
            endcase
        end else if (r_state == sts_pkg::ST_SCAN && w_done) begin
            w_load  = 1'b1;
            n_found = w_probe[STACK_DEPTH].hit;
            if (r_query.kind != sts_pkg::KIND_LIST) begin
                n_out_tag   = w_probe[STACK_DEPTH].tag;
                n_out_level = w_probe[STACK_DEPTH].level;
            end
            // drop the bottom entry; nothing moves since cell 0 is the top
            if (r_query.kind == sts_pkg::KIND_SHIFT && w_probe[STACK_DEPTH].hit) begin
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sts_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_found     <= n_found;
            r_out_tag   <= n_out_tag;
            r_out_level <= n_out_level;
        end
        if (w_accept) begin
            r_query.kind  <= w_kind;
            r_query.tag   <= i_item_tag;
            r_query.level <= i_item_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list[0] <= sts_pkg::LIST_A_RST;
            r_list[1] <= sts_pkg::LIST_B_RST;
            r_list[2] <= sts_pkg::LIST_C_RST;
            r_list[3] <= sts_pkg::LIST_D_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                sts_pkg::CFG_LIST_A: r_list[0] <= i_cfg_wdata;
                sts_pkg::CFG_LIST_B: r_list[1] <= i_cfg_wdata;
                sts_pkg::CFG_LIST_C: r_list[2] <= i_cfg_wdata;
                sts_pkg::CFG_LIST_D: r_list[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Inject a fresh probe into the top cell
    always_comb begin
        w_probe[0]     = '0;
        w_probe[0].run = w_launch;
    end

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [sts_pkg::TAG_W-1:0]   w_below_tag;
        logic [sts_pkg::LEVEL_W-1:0] w_below_level;
        logic [sts_pkg::TAG_W-1:0]   w_above_tag;
        logic [sts_pkg::LEVEL_W-1:0] w_above_level;

        if (g == 0) begin : g_top
            assign w_below_tag   = i_item_tag;
            assign w_below_level = i_item_level;
        end else begin : g_mid
            assign w_below_tag   = w_tag[g-1];
            assign w_below_level = w_level[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_last
            assign w_above_tag   = w_tag[g];
            assign w_above_level = w_level[g];
        end else begin : g_inner
            assign w_above_tag   = w_tag[g+1];
            assign w_above_level = w_level[g+1];
        end

        sts_cell #(
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_below_tag   (w_below_tag),
            .i_below_level (w_below_level),
            .i_above_tag   (w_above_tag),
            .i_above_level (w_above_level),
            .i_count       (r_count),
            .i_query       (r_query),
            .i_list_tags   (r_list),
            .i_probe       (w_probe[g]),
            .o_probe       (w_probe[g+1]),
            .o_tag         (w_tag[g]),
            .o_level       (w_level[g])
        );
    end

    assign w_count_ext   = {6'd0, r_count};
    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_out_tag     = r_out_tag;
    assign o_out_level   = r_out_level;
    assign o_entry_count = w_count_ext[5:0];
    assign o_is_empty    = r_count == '0;
    assign o_is_full     = r_count == FULL_CNT;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above stack depth");

    a_probe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_probe[STACK_DEPTH].run |-> (r_state == sts_pkg::ST_SCAN))
        else $error("probe left the row outside a scan");

    a_scan_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_scan_kind) |=> (r_state == sts_pkg::ST_LAUNCH) && !o_in_ready)
        else $error("search item did not launch a probe");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sts_pkg::ST_SCAN && w_done) |=> o_out_valid)
        else $error("finished search gave no result item");

endmodule

@@ src/sts_cell.sv @@
// One stack entry cell: holds an entry, shifts with its neighbors, checks the passing probe.
module sts_cell #(
    parameter int CNT_W = 6,
    parameter int IDX   = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sts_pkg::t_shift_ctl         i_ctl,
    input  logic [sts_pkg::TAG_W-1:0]   i_below_tag,
    input  logic [sts_pkg::LEVEL_W-1:0] i_below_level,
    input  logic [sts_pkg::TAG_W-1:0]   i_above_tag,
    input  logic [sts_pkg::LEVEL_W-1:0] i_above_level,
    input  logic [CNT_W-1:0]            i_count,
    input  sts_pkg::t_query             i_query,
    input  sts_pkg::t_list_tags         i_list_tags,
    input  sts_pkg::t_probe             i_probe,
    output sts_pkg::t_probe             o_probe,
    output logic [sts_pkg::TAG_W-1:0]   o_tag,
    output logic [sts_pkg::LEVEL_W-1:0] o_level
);

    logic [sts_pkg::TAG_W-1:0]   r_tag;
    logic [sts_pkg::LEVEL_W-1:0] r_level;
    sts_pkg::t_probe             r_probe;
    sts_pkg::t_probe             n_probe;
    logic                        w_live;
    logic                        w_bottom;
    logic                        w_is_list;
    logic                        w_level_up;
    logic                        w_hit;

    assign w_live     = CNT_W'(IDX) < i_count;
    assign w_bottom   = CNT_W'(IDX + 1) == i_count;
    assign w_is_list  = (r_tag == i_list_tags[0]) || (r_tag == i_list_tags[1]) ||
                        (r_tag == i_list_tags[2]) || (r_tag == i_list_tags[3]);
    assign w_level_up = ({1'b0, r_level} + (sts_pkg::LEVEL_W+1)'(1)) == {1'b0, i_query.level};

    always_comb begin
        case (i_query.kind)
            sts_pkg::KIND_SHIFT:  w_hit = w_bottom;
            sts_pkg::KIND_MATCH:  w_hit = w_live && (r_tag == i_query.tag) &&
                                          (r_level == i_query.level);
            sts_pkg::KIND_NEWEST: w_hit = w_live && (r_tag == i_query.tag);
            sts_pkg::KIND_LIST:   w_hit = w_live && w_level_up && w_is_list;
            default:              w_hit = 1'b0;
        endcase
    end

    // Keep the first hit; cell 0 is the newest entry
    always_comb begin
        n_probe = i_probe;
        if (i_probe.run && !i_probe.hit && w_hit) begin
            n_probe.hit   = 1'b1;
            n_probe.tag   = r_tag;
            n_probe.level = r_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_tag   <= i_below_tag;
            r_level <= i_below_level;
        end else if (i_ctl.pop) begin
            r_tag   <= i_above_tag;
            r_level <= i_above_level;
        end
    end

    assign o_probe = r_probe;
    assign o_tag   = r_tag;
    assign o_level = r_level;

endmodule
